>>> rtl/core/sicp_pkg.sv
// shared types and codes for the sparse image chunk parser
`timescale 1ns / 1ps
`default_nettype none

package sicp_pkg;

    localparam int unsigned CFG_INDEX_W = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PARTITION_LIMIT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_OFFSET     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_MAGIC   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAW_CODE         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_CODE        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILE_HEADER_LEN  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHUNK_HEADER_LEN = 3'd6;

    // register reset values
    localparam logic [31:0] MAGIC_RESET       = 32'hED26_FF3A;
    localparam logic [15:0] RAW_CODE_RESET    = 16'hCAC1;
    localparam logic [15:0] SKIP_CODE_RESET   = 16'hCAC3;
    localparam logic [15:0] FILE_HDR_RESET    = 16'd28;
    localparam logic [15:0] CHUNK_HDR_RESET   = 16'd12;
    localparam logic [15:0] FORMAT_MAJOR      = 16'd1;

    // item kinds
    localparam logic CMD_FILE_HEADER  = 1'b0;
    localparam logic CMD_CHUNK_HEADER = 1'b1;

    // result actions
    localparam logic [1:0] ACT_HEADER_OK = 2'd0;
    localparam logic [1:0] ACT_WRITE     = 2'd1;
    localparam logic [1:0] ACT_SKIP      = 2'd2;
    localparam logic [1:0] ACT_ERROR     = 2'd3;

    // error codes
    localparam logic [3:0] ERR_NONE          = 4'd0;
    localparam logic [3:0] ERR_IMAGE_TOO_BIG = 4'd1;
    localparam logic [3:0] ERR_BAD_MAGIC     = 4'd2;
    localparam logic [3:0] ERR_INCOMPATIBLE  = 4'd3;
    localparam logic [3:0] ERR_BAD_RAW_SIZE  = 4'd4;
    localparam logic [3:0] ERR_RAW_OVERFLOW  = 4'd5;
    localparam logic [3:0] ERR_BAD_SKIP_SIZE = 4'd6;
    localparam logic [3:0] ERR_SKIP_OVERFLOW = 4'd7;
    localparam logic [3:0] ERR_UNKNOWN_TYPE  = 4'd8;
    localparam logic [3:0] ERR_UNEXPECTED    = 4'd9;

    typedef struct packed {
        logic        cmd;
        logic [31:0] magic_word;
        logic [15:0] format_major;
        logic [15:0] header_bytes;
        logic [15:0] chunk_header_bytes;
        logic [31:0] block_bytes;
        logic [31:0] image_blocks;
        logic [31:0] image_chunks;
        logic [15:0] kind_code;
        logic [31:0] span_blocks;
        logic [31:0] span_bytes_total;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  error_code;
        logic [31:0] dest_offset;
        logic [31:0] span_length;
        logic [31:0] chunk_number;
        logic        image_done;
    } out_item_t;

endpackage

`default_nettype wire

>>> rtl/core/sicp_in_if.sv
// header item channel
`timescale 1ns / 1ps
`default_nettype none

interface sicp_in_if import sicp_pkg::*;;
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sicp_out_if.sv
// result channel
`timescale 1ns / 1ps
`default_nettype none

interface sicp_out_if import sicp_pkg::*;;
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sicp_cfg_if.sv
// configuration write channel
`timescale 1ns / 1ps
`default_nettype none

interface sicp_cfg_if import sicp_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [31:0]            wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sparse_image_chunk_parser.sv
// sparse image header checker: turns file and chunk headers into write/skip commands
//
// channels: item (sink) takes a decoded file header (cmd 0) or chunk header (cmd 1);
// result (source) gives exactly one transaction per item: header accepted, write span,
// skip span or error with its code; cfg (sink, always ready) writes the seven registers
// by index, indexes above six are dropped.
// an item is held in the input register; its result goes to the result register.
// throughput: one item per cycle while result is taken; the single 32x32 multiplier
// in the check stage (image size or chunk span times block size) sets the cycle time.
// the input register and the result register are separate, so a new item is taken
// while a finished result still waits; when the receiver stalls, one more item is
// held in the input register and item.ready then drops until result is taken.
// reset: no image is open, offsets and counts are zero, registers take their
// default codes (magic, raw and skip codes, header sizes); a file header item that
// passes its checks restarts parsing from start_offset.
`timescale 1ns / 1ps
`default_nettype none

module sparse_image_chunk_parser import sicp_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    sicp_in_if.sink    item,
    sicp_out_if.source result,
    sicp_cfg_if.sink   cfg
);

    // configuration registers
    logic [31:0] partition_limit_reg;
    logic [31:0] start_offset_reg;
    logic [31:0] expected_magic_reg;
    logic [15:0] raw_code_reg;
    logic [15:0] skip_code_reg;
    logic [15:0] file_header_len_reg;
    logic [15:0] chunk_header_len_reg;

    // parse state
    logic        header_valid_reg, header_valid_next;
    logic        failed_reg, failed_next;
    logic [31:0] block_size_kept_reg, block_size_kept_next;
    logic [31:0] chunks_expected_reg, chunks_expected_next;
    logic [31:0] chunks_seen_reg, chunks_seen_next;
    logic [32:0] bytes_out_reg, bytes_out_next;
    logic [31:0] next_offset_reg, next_offset_next;

    // pipeline
    logic        in_vld_reg;
    in_item_t    in_data_reg;
    logic        out_vld_reg;
    out_item_t   out_data_reg;
    out_item_t   res;
    logic        advance;

    // datapath
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [64:0] run_sum;
    logic [64:0] raw_total;
    logic        over_limit;
    logic        hdr_too_big;
    logic        hdr_incompat;
    logic        unexpected;
    logic [31:0] seen_plus_one;
    logic [3:0]  err;

    assign advance     = in_vld_reg && (!out_vld_reg || result.ready);
    assign item.ready  = !in_vld_reg || advance;
    assign cfg.ready   = 1'b1;
    assign result.valid = out_vld_reg;
    assign result.data  = out_data_reg;

    // one shared multiplier: image size for a file header, span length for a chunk
    assign mul_a = (in_data_reg.cmd == CMD_FILE_HEADER) ? in_data_reg.image_blocks
                                                        : in_data_reg.span_blocks;
    assign mul_b = (in_data_reg.cmd == CMD_FILE_HEADER) ? in_data_reg.block_bytes
                                                        : block_size_kept_reg;
    assign prod  = 64'(mul_a) * 64'(mul_b);

    assign run_sum    = {32'd0, bytes_out_reg} + {1'b0, prod};
    assign raw_total  = {1'b0, prod} + {49'd0, chunk_header_len_reg};
    assign over_limit = run_sum > {33'd0, partition_limit_reg};
    assign hdr_too_big = prod > {32'd0, partition_limit_reg};
    assign hdr_incompat = (in_data_reg.format_major != FORMAT_MAJOR)
                       || (in_data_reg.header_bytes != file_header_len_reg)
                       || (in_data_reg.chunk_header_bytes != chunk_header_len_reg);
    assign unexpected = !header_valid_reg || failed_reg
                     || (chunks_seen_reg >= chunks_expected_reg);
    assign seen_plus_one = chunks_seen_reg + 32'd1;

    always_comb
    begin
        res                  = '0;
        err                  = ERR_NONE;
        header_valid_next    = header_valid_reg;
        failed_next          = failed_reg;
        block_size_kept_next = block_size_kept_reg;
        chunks_expected_next = chunks_expected_reg;
        chunks_seen_next     = chunks_seen_reg;
        bytes_out_next       = bytes_out_reg;
        next_offset_next     = next_offset_reg;

        if (in_data_reg.cmd == CMD_FILE_HEADER)
        begin
            if (hdr_too_big)
                err = ERR_IMAGE_TOO_BIG;
            else if (in_data_reg.magic_word != expected_magic_reg)
                err = ERR_BAD_MAGIC;
            else if (hdr_incompat)
                err = ERR_INCOMPATIBLE;

            if (err != ERR_NONE)
            begin
                header_valid_next = 1'b0;
                failed_next       = 1'b1;
                res.action        = ACT_ERROR;
                res.error_code    = err;
            end
            else
            begin
                header_valid_next    = 1'b1;
                failed_next          = 1'b0;
                block_size_kept_next = in_data_reg.block_bytes;
                chunks_expected_next = in_data_reg.image_chunks;
                chunks_seen_next     = '0;
                bytes_out_next       = '0;
                next_offset_next     = start_offset_reg;
                res.action           = ACT_HEADER_OK;
                res.dest_offset      = start_offset_reg;
                res.image_done       = (in_data_reg.image_chunks == 32'd0);
            end
        end
        else
        begin
            res.dest_offset  = next_offset_reg;
            res.chunk_number = chunks_seen_reg;
            if (unexpected)
            begin
                res.action     = ACT_ERROR;
                res.error_code = ERR_UNEXPECTED;
            end
            else
            begin
                // raw wins when both codes are equal
                if (in_data_reg.kind_code == raw_code_reg)
                begin
                    res.action = ACT_WRITE;
                    if ({33'd0, in_data_reg.span_bytes_total} != raw_total)
                        err = ERR_BAD_RAW_SIZE;
                    else if (over_limit)
                        err = ERR_RAW_OVERFLOW;
                end
                else if (in_data_reg.kind_code == skip_code_reg)
                begin
                    res.action = ACT_SKIP;
                    if (in_data_reg.span_bytes_total != {16'd0, chunk_header_len_reg})
                        err = ERR_BAD_SKIP_SIZE;
                    else if (over_limit)
                        err = ERR_SKIP_OVERFLOW;
                end
                else
                begin
                    err = ERR_UNKNOWN_TYPE;
                end

                if (err != ERR_NONE)
                begin
                    failed_next    = 1'b1;
                    res.action     = ACT_ERROR;
                    res.error_code = err;
                end
                else
                begin
                    res.span_length  = prod[31:0];
                    res.image_done   = (seen_plus_one == chunks_expected_reg);
                    bytes_out_next   = run_sum[32:0];
                    next_offset_next = next_offset_reg + prod[31:0];
                    chunks_seen_next = seen_plus_one;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partition_limit_reg  <= '0;
            start_offset_reg     <= '0;
            expected_magic_reg   <= MAGIC_RESET;
            raw_code_reg         <= RAW_CODE_RESET;
            skip_code_reg        <= SKIP_CODE_RESET;
            file_header_len_reg  <= FILE_HDR_RESET;
            chunk_header_len_reg <= CHUNK_HDR_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_PARTITION_LIMIT:  partition_limit_reg  <= cfg.wdata;
                CFG_START_OFFSET:     start_offset_reg     <= cfg.wdata;
                CFG_EXPECTED_MAGIC:   expected_magic_reg   <= cfg.wdata;
                CFG_RAW_CODE:         raw_code_reg         <= cfg.wdata[15:0];
                CFG_SKIP_CODE:        skip_code_reg        <= cfg.wdata[15:0];
                CFG_FILE_HEADER_LEN:  file_header_len_reg  <= cfg.wdata[15:0];
                CFG_CHUNK_HEADER_LEN: chunk_header_len_reg <= cfg.wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_valid_reg    <= 1'b0;
            failed_reg          <= 1'b0;
            block_size_kept_reg <= '0;
            chunks_expected_reg <= '0;
            chunks_seen_reg     <= '0;
            bytes_out_reg       <= '0;
            next_offset_reg     <= '0;
        end
        else if (advance)
        begin
            header_valid_reg    <= header_valid_next;
            failed_reg          <= failed_next;
            block_size_kept_reg <= block_size_kept_next;
            chunks_expected_reg <= chunks_expected_next;
            chunks_seen_reg     <= chunks_seen_next;
            bytes_out_reg       <= bytes_out_next;
            next_offset_reg     <= next_offset_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (item.valid && item.ready)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance)
                out_vld_reg <= 1'b1;
            else if (result.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            in_data_reg <= item.data;
        if (advance)
            out_data_reg <= res;
    end

endmodule

`default_nettype wire
